FILE: src/mlcd_fb_pkg.sv
`timescale 1ns / 1ps

package mlcd_fb_pkg;

	localparam int WIDTH = 128;
	localparam int HEIGHT = 64;
	localparam int ROW_BYTES = WIDTH / 8;
	localparam int STORE_BYTES = ROW_BYTES * HEIGHT;
	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int COL_W = $clog2(ROW_BYTES);
	localparam int ROW_W = $clog2(HEIGHT / 2);
	localparam int X_W = $clog2(WIDTH);
	localparam int Y_W = $clog2(HEIGHT);

	localparam logic [7:0] SYNC_CMD = 8'hF8;
	localparam logic [7:0] SYNC_DATA = 8'hFA;
	localparam logic [7:0] ADDR_BASE = 8'h80;
	localparam logic [7:0] NIBBLE_MASK = 8'hF0;

	localparam logic [5:0] GEN_CMD_FRAMES = 6'd2;
	localparam logic [5:0] GEN_LAST_REFRESH = 6'd33;
	localparam logic [5:0] GEN_LAST_INIT = 6'd6;

	typedef enum logic [1:0] {
		MODE_DRAW,
		MODE_CLEAR,
		MODE_REFRESH,
		MODE_INIT
	} mode_t;

	typedef struct packed {
		logic       is_cmd;
		logic [7:0] cmd_val;
		logic       start;
		logic       stop;
		logic       last;
	} frame_t;

	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] v;
		unique case (idx)
			3'd0: v = 8'h30;
			3'd1: v = 8'h30;
			3'd2: v = 8'h01;
			3'd3: v = 8'h06;
			3'd4: v = 8'h0C;
			3'd5: v = 8'h34;
			3'd6: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

FILE: src/mono_lcd_framebuffer_refresher.sv
`timescale 1ns / 1ps

// refresh: 34 words from ST_EMIT via frame_s1 and the output register, one per cycle
// unless m_axis_tready stalls; the next input word is taken only once the last word has
// left frame_s1; init: 7 words the same way; draw pixel: read (ST_DRAW_RD), modify and
// write (ST_DRAW_WR) of one byte, off-screen pixels dropped; clear: one byte written
// per cycle over all 1024 bytes; after reset the same clear runs before input is taken
// the frame store has one read and one write port, so one byte is read per output word

module mono_lcd_framebuffer_refresher
	import mlcd_fb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pixel_x, pixel_y, pixel_on, row_pair, zero fill
	input  logic [1:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // sync_byte, high_nibble_byte, low_nibble_byte,
	                                   // txn_start, txn_end, zero fill
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_q;

	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        mask_q;
	logic              on_q;
	logic [ROW_W-1:0]  row_q;
	logic              init_q;
	logic [5:0]        gen_q;

	logic   valid_s1;
	frame_t frame_s1;

	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_last_q;

	logic              adv;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_ra;
	logic [5:0]        gen_off;
	logic [ADDR_W-1:0] gen_addr;
	frame_t            gen_frame;
	logic              gen_done;
	logic [7:0]        out_val;

	logic [X_W:0]   in_x;
	logic [Y_W:0]   in_y;
	logic           in_on;
	logic [ROW_W-1:0] in_row;
	mode_t          in_mode;
	logic           in_area;

	assign in_x   = s_axis_tdata[7:0];
	assign in_y   = s_axis_tdata[14:8];
	assign in_on  = s_axis_tdata[15];
	assign in_row = s_axis_tdata[20:16];
	assign in_mode = mode_t'(s_axis_tuser);
	assign in_area = (in_x < (X_W+1)'(WIDTH)) && (in_y < (Y_W+1)'(HEIGHT));

	assign adv = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE) && !valid_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// data frames: offset 0..31, upper bit picks the lower half of the screen
	assign gen_off  = gen_q - GEN_CMD_FRAMES;
	assign gen_addr = {gen_off[COL_W], row_q, gen_off[COL_W-1:0]};
	assign gen_done = init_q ? (gen_q == GEN_LAST_INIT) : (gen_q == GEN_LAST_REFRESH);

	always_comb begin
		if (init_q) begin
			gen_frame.is_cmd  = 1'b1;
			gen_frame.cmd_val = init_cmd(gen_q[2:0]);
			gen_frame.start   = 1'b1;
			gen_frame.stop    = 1'b1;
			gen_frame.last    = gen_q == GEN_LAST_INIT;
		end else begin
			gen_frame.is_cmd  = gen_q < GEN_CMD_FRAMES;
			gen_frame.cmd_val = (gen_q == 6'd0) ? (ADDR_BASE | {3'b000, row_q}) : ADDR_BASE;
			gen_frame.start   = gen_q <= GEN_CMD_FRAMES;
			gen_frame.stop    = (gen_q < GEN_CMD_FRAMES) || (gen_q == GEN_LAST_REFRESH);
			gen_frame.last    = gen_q == GEN_LAST_REFRESH;
		end
	end

	always_comb begin
		mem_we = (state_q == ST_CLEAR) || (state_q == ST_DRAW_WR);
		mem_wa = addr_q;
		if (state_q == ST_CLEAR) begin
			mem_wd = 8'h00;
		end else if (on_q) begin
			mem_wd = rd_q | mask_q;
		end else begin
			mem_wd = rd_q & ~mask_q;
		end
		mem_re = (state_q == ST_DRAW_RD) || ((state_q == ST_EMIT) && adv);
		mem_ra = (state_q == ST_DRAW_RD) ? addr_q : gen_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign out_val = frame_s1.is_cmd ? frame_s1.cmd_val : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			mask_q      <= '0;
			on_q        <= 1'b0;
			row_q       <= '0;
			init_q      <= 1'b0;
			gen_q       <= '0;
			valid_s1    <= 1'b0;
			frame_s1    <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					out_data_q <= {6'b000000, frame_s1.stop, frame_s1.start,
						out_val[3:0], 4'b0000, out_val & NIBBLE_MASK,
						frame_s1.is_cmd ? SYNC_CMD : SYNC_DATA};
					out_last_q <= frame_s1.last;
				end
				valid_s1 <= (state_q == ST_EMIT);
			end

			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						unique case (in_mode)
							MODE_DRAW: begin
								addr_q <= {in_y[Y_W-1:0], in_x[X_W-1:3]};
								mask_q <= 8'h80 >> in_x[2:0];
								on_q   <= in_on;
								if (in_area) begin
									state_q <= ST_DRAW_RD;
								end
							end
							MODE_CLEAR: begin
								addr_q  <= '0;
								state_q <= ST_CLEAR;
							end
							MODE_REFRESH: begin
								row_q   <= in_row;
								init_q  <= 1'b0;
								gen_q   <= '0;
								state_q <= ST_EMIT;
							end
							MODE_INIT: begin
								init_q  <= 1'b1;
								gen_q   <= '0;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_DRAW_RD: begin
					state_q <= ST_DRAW_WR;
				end
				ST_DRAW_WR: begin
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (adv) begin
						frame_s1 <= gen_frame;
						gen_q    <= gen_q + 1'b1;
						if (gen_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
